FILE: design/dcasd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcasd_pkg
// shared types and constants of the dual-channel boxcar step detector
// ----------------------------------------------------------------------------
package dcasd_pkg;

  // ring depths must be powers of two (averages are taken by shifting)
  localparam int LONG_DEPTH  = 32;
  localparam int SHORT_DEPTH = 4;
  localparam int SAMPLE_BITS = 12;

  localparam int LONG_AW  = $clog2(LONG_DEPTH);
  localparam int SHORT_AW = $clog2(SHORT_DEPTH);
  localparam int LSUM_W   = SAMPLE_BITS + LONG_AW;
  localparam int SSUM_W   = SAMPLE_BITS + SHORT_AW;
  localparam int THR_W    = 12;
  localparam int TIMER_W  = 16;
  localparam int CMP_W    = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(300);

  // sequencer phases
  localparam logic [1:0] PH_WARM_LED  = 2'd0;
  localparam logic [1:0] PH_WARM_MEAS = 2'd1;
  localparam logic [1:0] PH_SAMP_LED  = 2'd2;
  localparam logic [1:0] PH_SAMP_MEAS = 2'd3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_left;
    logic [SAMPLE_BITS-1:0] sample_right;
    logic [TIMER_W-1:0]     timer_now;
  } in_item_t;

  typedef struct packed {
    logic                   led_on;
    logic                   warming;
    logic                   fire_left;
    logic                   fire_right;
    logic [TIMER_W-1:0]     capture_time;
    logic [SAMPLE_BITS-1:0] long_avg_left;
    logic [SAMPLE_BITS-1:0] long_avg_right;
    logic [SAMPLE_BITS-1:0] short_avg_left;
    logic [SAMPLE_BITS-1:0] short_avg_right;
  } out_item_t;

endpackage
`default_nettype wire

FILE: design/dual_channel_avg_step_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_channel_avg_step_detector
// two-channel long/short boxcar average step detector with led sequencer
// ----------------------------------------------------------------------------
// Each request is one converter event (left and right sample plus a timer
// value) and produces exactly one result. A request is taken every cycle
// unless in_stall holds it off; it first passes the read stage, which reads
// the ring memories at the current write pointers, and then the update stage,
// which updates the running sums, writes the new samples back and loads the
// output register that presents the result on out_data. Rings are held in
// two synchronous memories (long ring and short ring, both channels side by
// side in one word). Measure requests never follow each other directly, since
// led and measure phases alternate, so a read never meets a pending write to
// the same entry. No clearing pass is needed after reset: the rings are
// written strictly in pointer order, and a "ring full" flag per ring makes an
// entry that has not yet been written read as zero.
module dual_channel_avg_step_detector
  import dcasd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // event requests
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  // results
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  // threshold register write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [THR_W-1:0] cfg_data
);

  localparam logic [LONG_AW-1:0]  LONG_LAST  = LONG_AW'(LONG_DEPTH - 1);
  localparam logic [SHORT_AW-1:0] SHORT_LAST = SHORT_AW'(SHORT_DEPTH - 1);

  // what the read stage hands to the update stage
  typedef struct packed {
    logic                   push;
    logic                   sampling;
    logic                   led_on;
    logic                   warming;
    logic                   long_old_ok;
    logic                   short_old_ok;
    logic [LONG_AW-1:0]     long_idx;
    logic [SHORT_AW-1:0]    short_idx;
    logic [SAMPLE_BITS-1:0] sample_left;
    logic [SAMPLE_BITS-1:0] sample_right;
    logic [TIMER_W-1:0]     timer_now;
  } stage_t;

  // ring memories, both channels per word: [0] left, [1] right
  logic [1:0][SAMPLE_BITS-1:0] long_mem  [LONG_DEPTH];
  logic [1:0][SAMPLE_BITS-1:0] short_mem [SHORT_DEPTH];
  logic [1:0][SAMPLE_BITS-1:0] long_rd_r;
  logic [1:0][SAMPLE_BITS-1:0] short_rd_r;

  // control state
  logic [1:0]          phase_r, phase_nxt;
  logic [LONG_AW-1:0]  long_idx_r, long_idx_nxt;
  logic [SHORT_AW-1:0] short_idx_r, short_idx_nxt;
  logic                long_full_r, short_full_r;
  logic [THR_W-1:0]    thr_r;

  // running sums
  logic [1:0][LSUM_W-1:0] long_sum_r, long_sum_nxt;
  logic [1:0][SSUM_W-1:0] short_sum_r, short_sum_nxt;

  // pipeline
  stage_t    s1_r, s1_nxt;
  logic      s1_valid_r;
  logic      s1_go;
  logic      accept;
  out_item_t out_r, out_nxt;
  logic      out_valid_r;

  logic                           push0;
  logic [1:0][SAMPLE_BITS-1:0]    new_smp;
  logic [1:0][SAMPLE_BITS-1:0]    long_old, short_old;
  logic [1:0][SAMPLE_BITS-1:0]    long_avg, short_avg;
  logic [1:0]                     fire;

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  // update stage moves on when the output register is free or being emptied
  assign s1_go     = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_go;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // read stage: sequencer and ring pointers
  // ---------------------------------------------------------------------------
  assign push0 = (phase_r == PH_WARM_MEAS) || (phase_r == PH_SAMP_MEAS);

  always_comb begin
    long_idx_nxt  = (long_idx_r == LONG_LAST) ? '0 : long_idx_r + 1'b1;
    short_idx_nxt = (short_idx_r == SHORT_LAST) ? '0 : short_idx_r + 1'b1;
    case (phase_r)
      PH_WARM_LED:  phase_nxt = PH_WARM_MEAS;
      // warm-up ends once the long pointer has just reached its last entry
      PH_WARM_MEAS: phase_nxt = (long_idx_nxt == LONG_LAST) ? PH_SAMP_LED : PH_WARM_LED;
      PH_SAMP_LED:  phase_nxt = PH_SAMP_MEAS;
      PH_SAMP_MEAS: phase_nxt = PH_SAMP_LED;
      default:      phase_nxt = PH_WARM_LED;
    endcase

    s1_nxt.push         = push0;
    s1_nxt.sampling     = (phase_r == PH_SAMP_MEAS);
    s1_nxt.led_on       = (phase_r == PH_WARM_LED) || (phase_r == PH_SAMP_LED);
    s1_nxt.warming      = (phase_nxt == PH_WARM_LED) || (phase_nxt == PH_WARM_MEAS);
    s1_nxt.long_old_ok  = long_full_r;
    s1_nxt.short_old_ok = short_full_r;
    s1_nxt.long_idx     = long_idx_r;
    s1_nxt.short_idx    = short_idx_r;
    s1_nxt.sample_left  = in_data.sample_left;
    s1_nxt.sample_right = in_data.sample_right;
    s1_nxt.timer_now    = in_data.timer_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WARM_LED;
      long_idx_r   <= '0;
      short_idx_r  <= '0;
      long_full_r  <= 1'b0;
      short_full_r <= 1'b0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        s1_valid_r <= 1'b1;
        if (push0) begin
          long_idx_r  <= long_idx_nxt;
          short_idx_r <= short_idx_nxt;
          if (long_idx_r == LONG_LAST) begin
            long_full_r <= 1'b1;
          end
          if (short_idx_r == SHORT_LAST) begin
            short_full_r <= 1'b1;
          end
        end
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // stage payload and ring reads, held while the update stage is stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r       <= s1_nxt;
      long_rd_r  <= long_mem[long_idx_r];
      short_rd_r <= short_mem[short_idx_r];
    end
  end

  // ---------------------------------------------------------------------------
  // update stage: sums, detection, write-back
  // ---------------------------------------------------------------------------
  always_comb begin
    new_smp[0] = s1_r.sample_left;
    new_smp[1] = s1_r.sample_right;
    for (int ch = 0; ch < 2; ch++) begin
      // entries not yet written since reset count as zero
      long_old[ch]  = s1_r.long_old_ok ? long_rd_r[ch] : '0;
      short_old[ch] = s1_r.short_old_ok ? short_rd_r[ch] : '0;
      if (s1_r.push) begin
        long_sum_nxt[ch]  = long_sum_r[ch] - LSUM_W'(long_old[ch]) + LSUM_W'(new_smp[ch]);
        short_sum_nxt[ch] = short_sum_r[ch] - SSUM_W'(short_old[ch])
                            + SSUM_W'(new_smp[ch]);
      end else begin
        long_sum_nxt[ch]  = long_sum_r[ch];
        short_sum_nxt[ch] = short_sum_r[ch];
      end
      long_avg[ch]  = long_sum_nxt[ch][LSUM_W-1:LONG_AW];
      short_avg[ch] = short_sum_nxt[ch][SSUM_W-1:SHORT_AW];
      // widened compare so average plus threshold never wraps
      fire[ch] = s1_r.sampling &&
                 (CMP_W'(short_avg[ch]) > (CMP_W'(long_avg[ch]) + CMP_W'(thr_r)));
    end

    out_nxt.led_on          = s1_r.led_on;
    out_nxt.warming         = s1_r.warming;
    out_nxt.fire_left       = fire[0];
    out_nxt.fire_right      = fire[1];
    out_nxt.capture_time    = (fire[0] || fire[1]) ? s1_r.timer_now : '0;
    out_nxt.long_avg_left   = long_avg[0];
    out_nxt.long_avg_right  = long_avg[1];
    out_nxt.short_avg_left  = short_avg[0];
    out_nxt.short_avg_right = short_avg[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_sum_r  <= '0;
      short_sum_r <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
    end else begin
      if (s1_valid_r && s1_go) begin
        long_sum_r  <= long_sum_nxt;
        short_sum_r <= short_sum_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go) begin
      out_r <= out_nxt;
    end
  end

  // write-back of the new samples
  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go && s1_r.push) begin
      long_mem[s1_r.long_idx]   <= new_smp;
      short_mem[s1_r.short_idx] <= new_smp;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a detection only happens in a sampling measure phase, so the led is dark
  // and warm-up is over
  a_fire_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.fire_left || out_r.fire_right) |-> !out_r.warming && !out_r.led_on)
    else $error("detection outside a sampling measure phase");

  // no captured time without a detection
  a_capture_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.fire_left && !out_r.fire_right |-> out_r.capture_time == '0)
    else $error("capture time without detection");

  // a measure phase is never followed directly by another measure phase
  a_no_back_to_back_push: assert property (@(posedge clk) disable iff (!rst_n)
    accept && push0 |=> !push0)
    else $error("measure phase followed by measure phase");

  // a stalled update stage keeps its request
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_r))
    else $error("update stage lost a request under stall");

endmodule
`default_nettype wire

FILE: bench/dual_channel_avg_step_detector_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_channel_avg_step_detector_test
// self-checking bench for the dual-channel boxcar step detector
// ----------------------------------------------------------------------------
// Converter events go into the block through the valid/stall request channel.
// A scoreboard keeps its own copy of the sequencer, the boxcar rings and the
// threshold, works out the result of every accepted request and compares each
// result that leaves the block field by field with the oldest one due.
// Stimulus opens with a few extreme events during warm-up. It then plays
// random scenes: a steady level per channel, with or without noise, followed
// by a step up or down or by no step. Between scenes there are bursts of plain
// noise. The threshold is rewritten between phases, only once the block has
// gone quiet, and runs through zero, full scale and values in between.
// ----------------------------------------------------------------------------
module dual_channel_avg_step_detector_test;
  import dcasd_pkg::*;

  // expected behaviour of the detector, one result per request
  class detector_scoreboard;
    logic [THR_W-1:0]       threshold;
    logic [1:0]             phase;
    logic [SAMPLE_BITS-1:0] long_ring [2][LONG_DEPTH];
    logic [SAMPLE_BITS-1:0] short_ring [2][SHORT_DEPTH];
    logic [LSUM_W-1:0]      long_sum [2];
    logic [SSUM_W-1:0]      short_sum [2];
    logic [LONG_AW-1:0]     long_ptr [2];
    logic [SHORT_AW-1:0]    short_ptr [2];
    out_item_t              due_results [$];
    int                     mismatch_count;

    function new();
      threshold = THR_RESET;
      phase = PH_WARM_LED;
      foreach (long_ring[c, i]) long_ring[c][i] = '0;
      foreach (short_ring[c, i]) short_ring[c][i] = '0;
      for (int ch = 0; ch < 2; ch++) begin
        long_sum[ch] = '0;
        short_sum[ch] = '0;
        long_ptr[ch] = '0;
        short_ptr[ch] = '0;
      end
      mismatch_count = 0;
    endfunction

    // one sample into both boxcars of a channel
    function void push_sample(int ch, logic [SAMPLE_BITS-1:0] s);
      long_sum[ch] = long_sum[ch] - long_ring[ch][long_ptr[ch]] + s;
      long_ring[ch][long_ptr[ch]] = s;
      long_ptr[ch] = long_ptr[ch] + 1'b1;
      short_sum[ch] = short_sum[ch] - short_ring[ch][short_ptr[ch]] + s;
      short_ring[ch][short_ptr[ch]] = s;
      short_ptr[ch] = short_ptr[ch] + 1'b1;
    endfunction

    function logic [SAMPLE_BITS-1:0] long_avg(int ch);
      return SAMPLE_BITS'(long_sum[ch] / LONG_DEPTH);
    endfunction

    function logic [SAMPLE_BITS-1:0] short_avg(int ch);
      return SAMPLE_BITS'(short_sum[ch] / SHORT_DEPTH);
    endfunction

    function void note_event(in_item_t ev);
      out_item_t              res;
      logic [SAMPLE_BITS-1:0] s [2];
      logic [CMP_W-1:0]       bound;
      logic                   fired [2];
      res = '0;
      s[0] = ev.sample_left;
      s[1] = ev.sample_right;
      fired[0] = 1'b0;
      fired[1] = 1'b0;
      case (phase)
        PH_WARM_MEAS: begin
          push_sample(0, s[0]);
          push_sample(1, s[1]);
          phase = (long_ptr[0] == LONG_AW'(LONG_DEPTH - 1)) ? PH_SAMP_LED : PH_WARM_LED;
        end
        PH_SAMP_MEAS: begin
          push_sample(0, s[0]);
          push_sample(1, s[1]);
          for (int ch = 0; ch < 2; ch++) begin
            // threshold sum is taken one bit wider so it cannot wrap
            bound = CMP_W'(long_avg(ch)) + CMP_W'(threshold);
            if (CMP_W'(short_avg(ch)) > bound) begin
              fired[ch] = 1'b1;
              res.capture_time = ev.timer_now;
            end
          end
          phase = PH_SAMP_LED;
        end
        PH_SAMP_LED: begin
          phase = PH_SAMP_MEAS;
          res.led_on = 1'b1;
        end
        default: begin
          phase = PH_WARM_MEAS;
          res.led_on = 1'b1;
        end
      endcase
      res.warming = (phase == PH_WARM_LED) || (phase == PH_WARM_MEAS);
      res.fire_left = fired[0];
      res.fire_right = fired[1];
      res.long_avg_left = long_avg(0);
      res.long_avg_right = long_avg(1);
      res.short_avg_left = short_avg(0);
      res.short_avg_right = short_avg(1);
      due_results.push_back(res);
    endfunction

    function void report(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      string     diffs;
      if (due_results.size() == 0) begin
        report($sformatf("mismatch: result %h with no request outstanding", got));
        return;
      end
      want = due_results.pop_front();
      diffs = "";
      if (got.led_on !== want.led_on) diffs = {diffs, " led_on"};
      if (got.warming !== want.warming) diffs = {diffs, " warming"};
      if (got.fire_left !== want.fire_left) diffs = {diffs, " fire_left"};
      if (got.fire_right !== want.fire_right) diffs = {diffs, " fire_right"};
      if (got.capture_time !== want.capture_time) diffs = {diffs, " capture_time"};
      if (got.long_avg_left !== want.long_avg_left) diffs = {diffs, " long_avg_left"};
      if (got.long_avg_right !== want.long_avg_right) diffs = {diffs, " long_avg_right"};
      if (got.short_avg_left !== want.short_avg_left) diffs = {diffs, " short_avg_left"};
      if (got.short_avg_right !== want.short_avg_right) diffs = {diffs, " short_avg_right"};
      if (diffs != "")
        report($sformatf("mismatch in%s: expected %h got %h", diffs, want, got));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;

  detector_scoreboard sb;
  logic [TIMER_W-1:0] timer_count = '0;
  bit                 tx_calm = 1'b0;

  dual_channel_avg_step_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // both channels are watched at the edge, before anything is redriven
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_event(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // free-running timer, with the odd jump so that every bit moves
  function automatic logic [TIMER_W-1:0] next_timer();
    if ($urandom_range(0, 15) == 0) timer_count = TIMER_W'($urandom_range(0, 65535));
    else timer_count = timer_count + TIMER_W'($urandom_range(1, 4000));
    return timer_count;
  endfunction

  function automatic in_item_t make_event(int left, int right, logic [TIMER_W-1:0] t);
    in_item_t ev;
    ev.sample_left = SAMPLE_BITS'(left);
    ev.sample_right = SAMPLE_BITS'(right);
    ev.timer_now = t;
    return ev;
  endfunction

  function automatic int clamp_sample(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // steady levels lean towards the ends of the range now and then
  function automatic int pick_level();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 200);
      1: return $urandom_range(3900, 4095);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // level after the step: unchanged, lower or higher
  function automatic int step_to(int level);
    case ($urandom_range(0, 3))
      0: return level;
      1: return clamp_sample(level - int'($urandom_range(100, 4095)));
      default: return clamp_sample(level + int'($urandom_range(100, 4095)));
    endcase
  endfunction

  function automatic int jitter(int level, int spread);
    return clamp_sample(level + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // one request; the gap before it is drawn afresh each time, and is zero while calm
  task automatic send_event(input in_item_t ev);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait for every outstanding result, then a little longer
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.threshold = value;
    cfg_valid <= 1'b0;
  endtask

  // scenes of a steady level then a step, mixed with bursts of plain noise
  task automatic play_scenes(input int n_events);
    int done, quiet_len, step_len, spread;
    int lvl_l, lvl_r, hi_l, hi_r;
    done = 0;
    while (done < n_events) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15) begin
        quiet_len = $urandom_range(4, 30);
        repeat (quiet_len)
          send_event(make_event($urandom_range(0, 4095), $urandom_range(0, 4095),
                                next_timer()));
        done += quiet_len;
      end else begin
        lvl_l = pick_level();
        lvl_r = pick_level();
        hi_l = step_to(lvl_l);
        hi_r = step_to(lvl_r);
        case ($urandom_range(0, 3))
          0: spread = 0;
          1: spread = 8;
          2: spread = 60;
          default: spread = 400;
        endcase
        quiet_len = $urandom_range(16, 90);
        step_len = $urandom_range(4, 24);
        for (int k = 0; k < quiet_len + step_len; k++)
          send_event(make_event(jitter((k < quiet_len) ? lvl_l : hi_l, spread),
                                jitter((k < quiet_len) ? lvl_r : hi_r, spread),
                                next_timer()));
        done += quiet_len + step_len;
      end
    end
  endtask

  // stall pattern of the result side, with calm stretches now and then
  initial begin : result_sink
    int hold, left_in_mode;
    bit calm;
    left_in_mode = 0;
    calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (left_in_mode == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        left_in_mode = $urandom_range(20, 120);
      end
      left_in_mode--;
      hold = calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [THR_W-1:0] settings [7];
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // extremes of every field, taken in during warm-up at the reset threshold
    send_event(make_event(0, 0, 16'h0000));
    send_event(make_event(4095, 4095, 16'hffff));
    send_event(make_event(12'haaa, 12'h555, 16'haaaa));
    send_event(make_event(12'h555, 12'haaa, 16'h5555));
    send_event(make_event(4095, 0, 16'h0000));
    send_event(make_event(0, 4095, 16'hffff));
    send_event(make_event(4095, 4095, 16'h0001));
    send_event(make_event(0, 0, 16'h8000));

    // rest of warm-up and the first sampling stretch
    play_scenes(190);

    settings[0] = '0;
    settings[1] = '1;
    settings[2] = THR_W'(1);
    settings[3] = THR_W'($urandom_range(0, 600));
    settings[4] = THR_W'(4094);
    settings[5] = THR_W'($urandom_range(0, 4095));
    settings[6] = THR_RESET;

    foreach (settings[i]) begin
      // sender holds off here until the block has delivered everything
      settle();
      write_threshold(settings[i]);
      // full-scale step: fires at zero threshold, never at full scale,
      // where a wrapped threshold sum would give a false fire
      if (i < 2) begin
        tx_calm = 1'b0;
        repeat (8) send_event(make_event(4095, 4095, next_timer()));
      end
      play_scenes(200);
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.due_results.size() == 0)
      $display("PASS dual_channel_avg_step_detector");
    else
      $display("FAIL dual_channel_avg_step_detector");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("FAIL dual_channel_avg_step_detector");
    $finish;
  end

endmodule
`default_nettype wire
